/* hw/rtl/gpls_pkg.sv */
// Shared definitions for the GPU pstate linear search unit: request and
// response payload types, command, phase and register codes, and defaults.
// No dependencies.
package gpls_pkg;

   // Default sizes handed to the top level.
   localparam int GPU_COUNT_DEF   = 8;
   localparam int MAX_PSTATES_DEF = 32;

   // Request commands.
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_COUNT  = 2'd1;
   localparam logic [1:0] CMD_SAMPLE = 2'd2;

   // Search phases kept per GPU.
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_LINEAR = 2'd1;
   localparam logic [1:0] PH_REF    = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_OPTIMIZE_ENABLE = 3'd0;
   localparam logic [2:0] CSR_PSTATE_JUMP     = 3'd1;
   localparam logic [2:0] CSR_FREQ_MARGIN     = 3'd2;
   localparam logic [2:0] CSR_UTIL_DROP       = 3'd3;
   localparam logic [2:0] CSR_POWER_DROP      = 3'd4;

   // Configuration reset values.
   localparam logic       RST_OPTIMIZE_ENABLE = 1'b0;
   localparam logic [4:0] RST_PSTATE_JUMP     = 5'd4;
   localparam logic [6:0] RST_FREQ_MARGIN     = 7'd3;
   localparam logic [6:0] RST_UTIL_DROP       = 7'd5;
   localparam logic [6:0] RST_POWER_DROP      = 7'd10;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  gpu_index;
      logic [4:0]  entry_index;
      logic [23:0] table_value;
      logic [5:0]  entry_count;
      logic [6:0]  util_pct;
      logic [23:0] measured_freq;
      logic [19:0] power_mw;
      logic        last_gpu;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_gpu;
      logic [23:0] freq_khz;
      logic [4:0]  chosen_pstate;
      logic        try_again;
      logic        round_done;
      logic        round_ready;
   } rsp_type;

endpackage

/* hw/rtl/gpu_pstate_linear_search_unit.sv */
// Top level of the GPU pstate linear search unit: per-GPU frequency governor
// built around a per-GPU state memory and a frequency table memory.
// Depends on gpls_pkg for payload types, codes and defaults.
//
//   channel   direction  handshake               payload
//   req_*     in         req_valid / req_stall   gpls_pkg::req_type
//   rsp_*     out        rsp_valid / rsp_stall   gpls_pkg::rsp_type
//   csr_*     in         csr_wen                 csr_index, csr_wdata
//
// A sample runs through acceptance (state read), selection (selected-frequency
// read), decision (with result-frequency read) and a response step that loads
// the response register; load and count requests end after selection. Reset
// is synchronous and clears the sequencer, configuration registers and per-GPU
// valid bits, not the table memory. A stalled response holds the sequencer in
// its last step; a request is still accepted while a response waits in the output.
module gpu_pstate_linear_search_unit #(
   parameter int GPU_COUNT   = gpls_pkg::GPU_COUNT_DEF,
   parameter int MAX_PSTATES = gpls_pkg::MAX_PSTATES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gpls_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gpls_pkg::rsp_type rsp_data,
   input  logic              csr_wen,
   input  logic [2:0]        csr_index,
   input  logic [6:0]        csr_wdata
);

   localparam int GPU_W  = (GPU_COUNT > 1) ? $clog2(GPU_COUNT) : 1;
   localparam int PS_W   = $clog2(MAX_PSTATES);
   localparam int CNT_W  = $clog2(MAX_PSTATES + 1);
   localparam int TBL_D  = GPU_COUNT * MAX_PSTATES;
   localparam int TA_W   = $clog2(TBL_D);
   localparam int JMP_W  = ((PS_W > 5) ? PS_W : 5) + 1;

   // Per-GPU state word. It is held in a memory; a GPU whose valid bit is
   // clear reads as all zero, which is its reset state.
   typedef struct packed {
      logic [1:0]       phase;
      logic [PS_W-1:0]  pstate;
      logic [6:0]       ref_util;
      logic [19:0]      ref_power;
      logic [CNT_W-1:0] count;
   } gst_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SEL  = 4'b0010,
      S_EVAL = 4'b0100,
      S_OUT  = 4'b1000
   } seq_type;

   // Configuration registers.
   logic       cfg_opt_ff;
   logic [4:0] cfg_jump_ff;
   logic [6:0] cfg_margin_ff;
   logic [6:0] cfg_udrop_ff;
   logic [6:0] cfg_pdrop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_opt_ff    <= gpls_pkg::RST_OPTIMIZE_ENABLE;
         cfg_jump_ff   <= gpls_pkg::RST_PSTATE_JUMP;
         cfg_margin_ff <= gpls_pkg::RST_FREQ_MARGIN;
         cfg_udrop_ff  <= gpls_pkg::RST_UTIL_DROP;
         cfg_pdrop_ff  <= gpls_pkg::RST_POWER_DROP;
      end else if (csr_wen) begin
         case (csr_index)
            gpls_pkg::CSR_OPTIMIZE_ENABLE: cfg_opt_ff    <= csr_wdata[0];
            gpls_pkg::CSR_PSTATE_JUMP:     cfg_jump_ff   <= csr_wdata[4:0];
            gpls_pkg::CSR_FREQ_MARGIN:     cfg_margin_ff <= csr_wdata;
            gpls_pkg::CSR_UTIL_DROP:       cfg_udrop_ff  <= csr_wdata;
            gpls_pkg::CSR_POWER_DROP:      cfg_pdrop_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and request capture.
   seq_type           state_ff, state_in;
   gpls_pkg::req_type req_ff;
   logic              req_acc;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         req_ff <= req_data;
      end
   end

   logic [GPU_W-1:0] gpu;
   logic             gpu_ok;
   logic             is_sample;
   logic             rsp_free;

   assign gpu       = GPU_W'(req_ff.gpu_index);
   assign gpu_ok    = (int'(req_ff.gpu_index) < GPU_COUNT);
   assign is_sample = (req_ff.cmd == gpls_pkg::CMD_SAMPLE);
   assign rsp_free  = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_acc) state_in = S_SEL;
         S_SEL:  state_in = (gpu_ok && is_sample) ? S_EVAL : S_IDLE;
         S_EVAL: state_in = S_OUT;
         S_OUT:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Per-GPU state memory, read once at acceptance and written back once
   // per count or sample request. Only one request is in flight, so a write
   // always lands before the next read and no forwarding is needed.
   gst_type          st_mem [GPU_COUNT];
   gst_type          st_rd_ff;
   logic             st_vld_rd_ff;
   logic [GPU_COUNT-1:0] gvld_ff;
   gst_type          st;
   gst_type          st_wdata;
   logic             st_wen;
   logic [GPU_W-1:0] req_gpu;

   assign req_gpu = GPU_W'(req_data.gpu_index);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         st_rd_ff     <= st_mem[req_gpu];
         st_vld_rd_ff <= gvld_ff[req_gpu];
      end
      if (st_wen) begin
         st_mem[gpu] <= st_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gvld_ff <= '0;
      end else if (st_wen) begin
         gvld_ff[gpu] <= 1'b1;
      end
   end

   assign st = st_vld_rd_ff ? st_rd_ff : '0;

   // Frequency table memory: one write port for load requests and one read
   // port shared by the selected-frequency and result-frequency reads.
   logic [23:0]     tbl_mem [TBL_D];
   logic [23:0]     tbl_rd_ff;
   logic [TA_W-1:0] tbl_raddr;
   logic [TA_W-1:0] tbl_waddr;
   logic            tbl_ren;
   logic            tbl_wen;
   logic [PS_W-1:0] rd_pstate;
   logic [PS_W-1:0] pick;

   assign rd_pstate = (state_ff == S_SEL) ? st.pstate : pick;
   assign tbl_raddr = TA_W'(gpu) * TA_W'(MAX_PSTATES) + TA_W'(rd_pstate);
   assign tbl_waddr = TA_W'(gpu) * TA_W'(MAX_PSTATES) + TA_W'(req_ff.entry_index);
   assign tbl_ren   = (state_ff == S_SEL) || (state_ff == S_EVAL);
   assign tbl_wen   = (state_ff == S_SEL) && gpu_ok && (req_ff.cmd == gpls_pkg::CMD_LOAD)
                      && (int'(req_ff.entry_index) < MAX_PSTATES);

   always_ff @(posedge clock) begin
      if (tbl_ren) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
      if (tbl_wen) begin
         tbl_mem[tbl_waddr] <= req_ff.table_value;
      end
   end

   // First step of a sample: the compares that need only the stored state
   // and the sample are taken here, together with the clamped jump target.
   logic [PS_W-1:0]  last_e;
   logic [JMP_W-1:0] nxt;
   logic [PS_W-1:0]  jmp;
   logic [27:0]      pwr_lhs;
   logic [27:0]      pwr_rhs;
   logic [PS_W-1:0]  last_ff;
   logic [PS_W-1:0]  jmp_ff;
   logic             util_ge_ff;
   logic             udrop_ok_ff;
   logic             pwr_ok_ff;

   always_comb begin
      last_e  = (st.count == '0) ? '0 : PS_W'(st.count - CNT_W'(1));
      nxt     = JMP_W'(st.pstate) + JMP_W'(cfg_jump_ff);
      jmp     = (nxt > JMP_W'(last_e)) ? last_e : PS_W'(nxt);
      pwr_lhs = 28'(st.ref_power) * 28'd100;
      pwr_rhs = 28'(cfg_pdrop_ff) * 28'(st.ref_power) + 28'(req_ff.power_mw) * 28'd100;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SEL) begin
         last_ff     <= last_e;
         jmp_ff      <= jmp;
         util_ge_ff  <= (req_ff.util_pct >= st.ref_util);
         udrop_ok_ff <= ((st.ref_util - req_ff.util_pct) < cfg_udrop_ff);
         pwr_ok_ff   <= (pwr_lhs < pwr_rhs);
      end
   end

   // Second step of a sample: the throttle check against the selected
   // frequency, then the phase decision and the state write-back.
   logic [30:0] meas_x;
   logic [30:0] sel_x;
   logic        margin_ok;
   logic        check_ok;
   gst_type     st_new;
   logic        retry;
   logic        rr_sum;
   logic        rr_ff;
   logic [PS_W-1:0] pick_ff;
   logic        retry_ff;
   logic        ready_ff;

   always_comb begin
      meas_x    = 31'(req_ff.measured_freq) * 31'd100;
      sel_x     = 31'(tbl_rd_ff) * 31'(7'd100 - cfg_margin_ff);
      margin_ok = (cfg_margin_ff < 7'd100) && (meas_x < sel_x);
      check_ok  = util_ge_ff || margin_ok || udrop_ok_ff || pwr_ok_ff;

      st_new = st;
      retry  = 1'b0;
      if (req_ff.util_pct == 7'd0) begin
         // An idle GPU drops to the lowest frequency and keeps its phase.
         pick = last_ff;
      end else begin
         pick = st.pstate;
         if (cfg_opt_ff) begin
            case (st.phase)
               gpls_pkg::PH_FIRST: begin
                  st_new.pstate    = '0;
                  st_new.ref_util  = req_ff.util_pct;
                  st_new.ref_power = req_ff.power_mw;
                  st_new.phase     = gpls_pkg::PH_REF;
                  retry            = 1'b1;
               end
               gpls_pkg::PH_REF: begin
                  st_new.ref_util  = req_ff.util_pct;
                  st_new.ref_power = req_ff.power_mw;
                  st_new.pstate    = jmp_ff;
                  st_new.phase     = gpls_pkg::PH_LINEAR;
                  retry            = 1'b1;
               end
               gpls_pkg::PH_LINEAR: begin
                  if (check_ok) begin
                     st_new.pstate = jmp_ff;
                     retry         = 1'b1;
                  end else begin
                     st_new.phase = gpls_pkg::PH_FIRST;
                  end
               end
               default: ;
            endcase
            pick = st_new.pstate;
         end
      end
      rr_sum = rr_ff || retry;
   end

   always_comb begin
      st_wen   = 1'b0;
      st_wdata = st;
      if ((state_ff == S_SEL) && gpu_ok && (req_ff.cmd == gpls_pkg::CMD_COUNT)) begin
         st_wen = 1'b1;
         st_wdata.count = (int'(req_ff.entry_count) > MAX_PSTATES) ?
                          CNT_W'(MAX_PSTATES) : CNT_W'(req_ff.entry_count);
      end else if (state_ff == S_EVAL) begin
         st_wen   = 1'b1;
         st_wdata = st_new;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         pick_ff  <= pick;
         retry_ff <= retry;
         ready_ff <= req_ff.last_gpu && !rr_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_ff <= 1'b0;
      end else if (state_ff == S_EVAL) begin
         rr_ff <= req_ff.last_gpu ? 1'b0 : rr_sum;
      end
   end

   // Response register.
   logic              rsp_valid_ff;
   gpls_pkg::rsp_type rsp_ff;
   logic              rsp_load;

   assign rsp_load = (state_ff == S_OUT) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.out_gpu       <= req_ff.gpu_index;
         rsp_ff.freq_khz      <= tbl_rd_ff;
         rsp_ff.chosen_pstate <= 5'(pick_ff);
         rsp_ff.try_again     <= retry_ff;
         rsp_ff.round_done    <= req_ff.last_gpu;
         rsp_ff.round_ready   <= ready_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A decision always moves on to the response step.
   a_eval_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |=> (state_ff == S_OUT))
      else $error("decision step not followed by response step");

   // The chosen pstate stays inside the table.
   a_pick_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |=> (int'(pick_ff) < MAX_PSTATES))
      else $error("chosen pstate beyond the table");

   // A response appears only out of the response step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the response step");

   // Round readiness is reported only on the last GPU of a round.
   a_ready_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.round_ready) |-> rsp_ff.round_done)
      else $error("round ready without round done");

endmodule
